// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the dither RTL.
// Uses the clk_i and rst_ni names of the including module; empty when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define GEDD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define GEDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define GEDD_ASSERT(lbl, prop, msg)
`define GEDD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/core/gedd_pkg.sv -----
// Types, constants and helper functions of the grey error-diffusion dither.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package gedd_pkg;

  // Frame geometry
  localparam int MaxWidth   = 1024;
  localparam int MaxHeight  = 4096;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int RowCntW    = $clog2(MaxHeight);

  // Configuration registers
  localparam int WidthRegW  = 11;
  localparam int HeightRegW = 13;
  localparam int CfgDataW   = HeightRegW;
  localparam int RegIdxW    = 1;

  typedef enum logic [RegIdxW-1:0] {
    RegImageWidth  = 1'b0,
    RegImageHeight = 1'b1
  } reg_idx_e;

  localparam logic [WidthRegW-1:0]  ResetWidth  = 11'd256;
  localparam logic [HeightRegW-1:0] ResetHeight = 13'd256;

  // Pixel arithmetic
  localparam int PixW       = 8;
  localparam int SumW       = 10;
  localparam int Div3ProdW  = 20;
  localparam int Div3Mul    = 683;  // floor(s * 683 / 2048) == floor(s / 3) for s <= 765
  localparam int Div3Shift  = 11;
  localparam int LevelW     = 4;
  localparam int QErrW      = 4;
  localparam logic [PixW-1:0] GreyMax = 8'hFF;

  // Error shares, weights over 16
  localparam int WgtW = 3;
  localparam logic [WgtW-1:0] WgtRight     = 3'd7;
  localparam logic [WgtW-1:0] WgtDown      = 3'd5;
  localparam logic [WgtW-1:0] WgtDownLeft  = 3'd3;

  // Carry store: rows of lanes, one valid bit per row
  localparam int LaneW      = 3;
  localparam int LaneCnt    = 8;
  localparam int LaneSelW   = $clog2(LaneCnt);
  localparam int RowCnt     = MaxWidth / LaneCnt;
  localparam int RowAddrW   = ColW - LaneSelW;

  // Queues
  localparam int FqDepth    = 4;
  localparam int FqPtrW     = $clog2(FqDepth);
  localparam int FqCntW     = FqPtrW + 1;
  localparam int OqDepth    = 2;
  localparam int OqPtrW     = $clog2(OqDepth);
  localparam int OqCntW     = OqPtrW + 1;

  typedef logic [LaneCnt-1:0][LaneW-1:0] lanes_t;

  typedef struct packed {
    logic [PixW-1:0] grey;
    logic [PixW-1:0] alpha;
    logic [ColW-1:0] col;
    logic            last_col;
    logic            last_row;
  } pix_t;

  typedef struct packed {
    logic [PixW-1:0]   dithered_grey;
    logic [LevelW-1:0] level;
    logic [PixW-1:0]   alpha;
    logic              frame_end;
  } res_t;

  typedef struct packed {
    logic             en;
    logic [ColW-1:0]  col;
    logic [LaneW-1:0] data;
  } store_wr_t;

  // Truncated share err * wgt / 16
  function automatic logic [LaneW-1:0] err_share(input logic [QErrW-1:0] err,
                                                 input logic [WgtW-1:0]  wgt);
    logic [QErrW+WgtW-1:0] prod;
    prod = {{WgtW{1'b0}}, err} * {{QErrW{1'b0}}, wgt};
    return prod[QErrW +: LaneW];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gedd_carry_store.sv -----
// Per-column carry store for the next row: lane-enable RAM with one valid bit per row.
// Depends on gedd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gedd_carry_store (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        rd_en_i,
  input  wire logic [gedd_pkg::ColW-1:0]   rd_col_i,
  input  wire gedd_pkg::store_wr_t         wr_i,
  input  wire logic                        clear_i,
  output gedd_pkg::lanes_t                 rd_lanes_o,
  output logic                             rd_valid_o
);

  gedd_pkg::lanes_t                  mem_q [gedd_pkg::RowCnt];
  gedd_pkg::lanes_t                  rd_q;
  logic [gedd_pkg::RowCnt-1:0]       row_valid_q;
  logic                              rd_valid_q;
  logic [gedd_pkg::RowAddrW-1:0]     wr_row;
  logic [gedd_pkg::LaneSelW-1:0]     wr_lane;
  logic [gedd_pkg::RowAddrW-1:0]     rd_row;

  assign wr_row  = wr_i.col[gedd_pkg::ColW-1:gedd_pkg::LaneSelW];
  assign wr_lane = wr_i.col[gedd_pkg::LaneSelW-1:0];
  assign rd_row  = rd_col_i[gedd_pkg::ColW-1:gedd_pkg::LaneSelW];

  // A write into an invalid row zero-fills the other lanes.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      for (int l = 0; l < gedd_pkg::LaneCnt; l++) begin
        if (!row_valid_q[wr_row] || (gedd_pkg::LaneSelW'(l) == wr_lane)) begin
          mem_q[wr_row][l] <= (gedd_pkg::LaneSelW'(l) == wr_lane) ? wr_i.data : '0;
        end
      end
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_row];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (clear_i) begin
        row_valid_q <= '0;
      end else if (wr_i.en) begin
        row_valid_q[wr_row] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= row_valid_q[rd_row] && !clear_i;
      end
    end
  end

  assign rd_lanes_o = rd_q;
  assign rd_valid_o = rd_valid_q;

endmodule

`default_nettype wire

// ----- rtl/core/gedd_front.sv -----
// Front end: configuration registers, frame position counters, grey conversion,
// and the request queue toward the back end. Depends on gedd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gedd_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [gedd_pkg::RegIdxW-1:0]      cfg_idx_i,
  input  wire logic [gedd_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [gedd_pkg::PixW-1:0]         red_i,
  input  wire logic [gedd_pkg::PixW-1:0]         green_i,
  input  wire logic [gedd_pkg::PixW-1:0]         blue_i,
  input  wire logic [gedd_pkg::PixW-1:0]         alpha_i,
  output gedd_pkg::pix_t                         head_o,
  output logic                                   head_valid_o,
  input  wire logic                              head_pop_i
);

  logic [gedd_pkg::WidthRegW-1:0]  width_q;
  logic [gedd_pkg::HeightRegW-1:0] height_q;
  logic [gedd_pkg::ColW-1:0]       col_q, col_d;
  logic [gedd_pkg::RowCntW-1:0]    row_q, row_d;
  logic [gedd_pkg::ColW-1:0]       last_col_idx, col;
  logic [gedd_pkg::RowCntW-1:0]    last_row_idx;
  logic [gedd_pkg::SumW-1:0]       sum;
  logic [gedd_pkg::Div3ProdW-1:0]  prod;
  gedd_pkg::pix_t                  pix;
  logic                            accept;

  gedd_pkg::pix_t                  fq_q [gedd_pkg::FqDepth];
  logic [gedd_pkg::FqPtrW-1:0]     fq_wr_q, fq_rd_q;
  logic [gedd_pkg::FqCntW-1:0]     fq_cnt_q, fq_cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gedd_pkg::ResetWidth;
      height_q <= gedd_pkg::ResetHeight;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == gedd_pkg::RegImageWidth) begin
        width_q <= cfg_data_i[gedd_pkg::WidthRegW-1:0];
      end else begin
        height_q <= cfg_data_i[gedd_pkg::HeightRegW-1:0];
      end
    end
  end

  // Clamp the geometry to the supported range.
  always_comb begin
    if (width_q == '0) begin
      last_col_idx = '0;
    end else if (32'(width_q) > gedd_pkg::MaxWidth) begin
      last_col_idx = gedd_pkg::ColW'(gedd_pkg::MaxWidth - 1);
    end else begin
      last_col_idx = gedd_pkg::ColW'(width_q - 1'b1);
    end
    if (height_q == '0) begin
      last_row_idx = '0;
    end else if (32'(height_q) > gedd_pkg::MaxHeight) begin
      last_row_idx = gedd_pkg::RowCntW'(gedd_pkg::MaxHeight - 1);
    end else begin
      last_row_idx = gedd_pkg::RowCntW'(height_q - 1'b1);
    end
  end

  assign col = (col_q > last_col_idx) ? last_col_idx : col_q;

  // Divide by three with a reciprocal multiply.
  assign sum  = gedd_pkg::SumW'(red_i) + gedd_pkg::SumW'(green_i) + gedd_pkg::SumW'(blue_i);
  assign prod = gedd_pkg::Div3ProdW'(sum) * gedd_pkg::Div3ProdW'(gedd_pkg::Div3Mul);

  always_comb begin
    pix.grey     = prod[gedd_pkg::Div3Shift +: gedd_pkg::PixW];
    pix.alpha    = alpha_i;
    pix.col      = col;
    pix.last_col = (col == last_col_idx);
    pix.last_row = (row_q >= last_row_idx);
  end

  assign full   = (fq_cnt_q == gedd_pkg::FqCntW'(gedd_pkg::FqDepth));
  assign accept = push && !full;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (pix.last_col && pix.last_row) begin
        col_d = '0;
        row_d = '0;
      end else if (pix.last_col) begin
        col_d = '0;
        row_d = gedd_pkg::RowCntW'(row_q + 1'b1);
      end else begin
        col_d = gedd_pkg::ColW'(col + 1'b1);
      end
    end
  end

  always_comb begin
    fq_cnt_d = fq_cnt_q;
    if (accept && !head_pop_i) begin
      fq_cnt_d = gedd_pkg::FqCntW'(fq_cnt_q + 1'b1);
    end else if (!accept && head_pop_i) begin
      fq_cnt_d = gedd_pkg::FqCntW'(fq_cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      fq_wr_q  <= '0;
      fq_rd_q  <= '0;
      fq_cnt_q <= '0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      fq_cnt_q <= fq_cnt_d;
      if (accept) begin
        fq_wr_q <= gedd_pkg::FqPtrW'(fq_wr_q + 1'b1);
      end
      if (head_pop_i) begin
        fq_rd_q <= gedd_pkg::FqPtrW'(fq_rd_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fq_q[fq_wr_q] <= pix;
    end
  end

  assign head_o       = fq_q[fq_rd_q];
  assign head_valid_o = (fq_cnt_q != '0);

endmodule

`default_nettype wire

// ----- rtl/core/gedd_back.sv -----
// Back end: carry lookup, quantization, error spreading and the result queue.
// Depends on gedd_pkg, gedd_carry_store and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gedd_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire gedd_pkg::pix_t              head_i,
  input  wire logic                        head_valid_i,
  output logic                             head_pop_o,
  output logic                             empty,
  input  wire logic                        pop,
  output gedd_pkg::res_t                   res_o
);

  gedd_pkg::pix_t                   s2_q;
  logic                             s2_v_q;
  logic                             s2_fire, load;
  gedd_pkg::lanes_t                 rd_lanes;
  logic                             rd_valid;
  logic                             ovr_v_q;
  logic [gedd_pkg::LaneW-1:0]       ovr_d_q;
  logic                             def_v_q;
  logic [gedd_pkg::ColW-1:0]        def_col_q;
  logic [gedd_pkg::LaneW-1:0]       def_data_q;
  gedd_pkg::store_wr_t              wr_a, wr;
  logic                             clear;
  logic [gedd_pkg::LaneW-1:0]       right_q, pend_q;
  logic [gedd_pkg::LaneW-1:0]       below;
  logic [gedd_pkg::PixW:0]          total;
  logic [gedd_pkg::PixW-1:0]        v;
  logic [gedd_pkg::QErrW-1:0]       err;
  gedd_pkg::res_t                   res;

  gedd_pkg::res_t                   oq_q [gedd_pkg::OqDepth];
  logic [gedd_pkg::OqPtrW-1:0]      oq_wr_q, oq_rd_q;
  logic [gedd_pkg::OqCntW-1:0]      oq_cnt_q;
  logic                             oq_pop;

  assign s2_fire    = s2_v_q && (oq_cnt_q != gedd_pkg::OqCntW'(gedd_pkg::OqDepth));
  assign load       = head_valid_i && (!s2_v_q || s2_fire);
  assign head_pop_o = load;

  gedd_carry_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (load),
    .rd_col_i   (head_i.col),
    .wr_i       (wr),
    .clear_i    (clear),
    .rd_lanes_o (rd_lanes),
    .rd_valid_o (rd_valid)
  );

  // Newest write wins: pending deferred write, then snooped write, then RAM.
  always_comb begin
    priority if (def_v_q && (def_col_q == s2_q.col)) begin
      below = def_data_q;
    end else if (ovr_v_q) begin
      below = ovr_d_q;
    end else if (rd_valid) begin
      below = rd_lanes[s2_q.col[gedd_pkg::LaneSelW-1:0]];
    end else begin
      below = '0;
    end
  end

  assign total = (gedd_pkg::PixW+1)'(s2_q.grey) + (gedd_pkg::PixW+1)'(right_q)
               + (gedd_pkg::PixW+1)'(below);
  assign v     = (total > (gedd_pkg::PixW+1)'(gedd_pkg::GreyMax)) ? gedd_pkg::GreyMax
                                                                 : total[gedd_pkg::PixW-1:0];
  assign err   = v[gedd_pkg::QErrW-1:0];

  always_comb begin
    res.dithered_grey = {v[gedd_pkg::PixW-1:gedd_pkg::QErrW], {gedd_pkg::QErrW{1'b0}}};
    res.level         = v[gedd_pkg::PixW-1:gedd_pkg::QErrW];
    res.alpha         = s2_q.alpha;
    res.frame_end     = s2_q.last_col && s2_q.last_row;
  end

  // Lower-left share joins the previous pixel's downward share.
  always_comb begin
    wr_a.en   = s2_fire && !s2_q.last_row && (s2_q.col != '0);
    wr_a.col  = gedd_pkg::ColW'(s2_q.col - 1'b1);
    wr_a.data = gedd_pkg::LaneW'(pend_q + gedd_pkg::err_share(err, gedd_pkg::WgtDownLeft));
    if (def_v_q) begin
      wr.en   = 1'b1;
      wr.col  = def_col_q;
      wr.data = def_data_q;
    end else begin
      wr = wr_a;
    end
  end

  assign clear = s2_fire && s2_q.last_col && s2_q.last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      ovr_v_q <= 1'b0;
      def_v_q <= 1'b0;
      right_q <= '0;
      pend_q  <= '0;
    end else begin
      if (load) begin
        s2_v_q <= 1'b1;
      end else if (s2_fire) begin
        s2_v_q <= 1'b0;
      end
      if (load) begin
        ovr_v_q <= wr.en && (wr.col == head_i.col) && !clear;
      end else if (wr.en && (wr.col == s2_q.col)) begin
        ovr_v_q <= 1'b1;
      end
      // Defer the last-column write to the next cycle; the next pixel is column zero.
      def_v_q <= s2_fire && s2_q.last_col && !s2_q.last_row;
      if (s2_fire) begin
        right_q <= s2_q.last_col ? '0 : gedd_pkg::err_share(err, gedd_pkg::WgtRight);
        if (s2_q.last_col) begin
          pend_q <= '0;
        end else if (!s2_q.last_row) begin
          pend_q <= gedd_pkg::err_share(err, gedd_pkg::WgtDown);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s2_q    <= head_i;
      ovr_d_q <= wr.data;
    end else if (wr.en && (wr.col == s2_q.col)) begin
      ovr_d_q <= wr.data;
    end
    def_col_q  <= s2_q.col;
    def_data_q <= gedd_pkg::err_share(err, gedd_pkg::WgtDown);
    if (s2_fire) begin
      oq_q[oq_wr_q] <= res;
    end
  end

  assign empty  = (oq_cnt_q == '0);
  assign oq_pop = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (s2_fire) begin
        oq_wr_q <= gedd_pkg::OqPtrW'(oq_wr_q + 1'b1);
      end
      if (oq_pop) begin
        oq_rd_q <= gedd_pkg::OqPtrW'(oq_rd_q + 1'b1);
      end
      if (s2_fire && !oq_pop) begin
        oq_cnt_q <= gedd_pkg::OqCntW'(oq_cnt_q + 1'b1);
      end else if (!s2_fire && oq_pop) begin
        oq_cnt_q <= gedd_pkg::OqCntW'(oq_cnt_q - 1'b1);
      end
    end
  end

  assign res_o = oq_q[oq_rd_q];

  `GEDD_ASSERT(a_single_write, !(def_v_q && wr_a.en), "deferred and in-row store writes collide")
  `GEDD_ASSERT(a_oq_bound, oq_cnt_q <= gedd_pkg::OqCntW'(gedd_pkg::OqDepth), "result queue overrun")
  `GEDD_ASSERT_NEXT(a_row_end_carry, s2_fire && s2_q.last_col, right_q == '0, "right carry crosses row")
  `GEDD_ASSERT_NEXT(a_def_after_last, s2_fire && s2_q.last_col && !s2_q.last_row, def_v_q, "missing last-column store write")

endmodule

`default_nettype wire

// ----- rtl/core/grey_error_diffusion_dither_top.sv -----
// Grey error-diffusion dither, 16 levels: top level.
// Depends on gedd_pkg, gedd_front and gedd_back.
//
// Usage:
//   Pixels (red_i, green_i, blue_i, alpha_i) enter in raster order through a
//   queue-like port: a pixel is taken on a clock edge with push high and full
//   low. Results (dithered_grey_o, level_o, alpha_out_o, frame_end_o) wait on
//   the output ports while empty is low and leave on an edge with pop high.
//   The registers image_width (index 0) and image_height (index 1) are written
//   through cfg_we_i / cfg_idx_i / cfg_data_i while no pixel is in flight.
//   Throughput is one pixel per clock while the result queue has room. A pixel
//   passes the front queue, then the back stage with the registered carry-store
//   read that feeds the quantizer, and its result then enters the result queue.
//   Reset clears position counters, error carries and the carry-store row
//   valid bits at once (no clearing pass); the registers return to 256 x 256.
//   If the receiver stalls, the result queue (2), the back stage (1) and the
//   front queue (4) absorb up to seven pixels before full rises.
`timescale 1ns / 1ps
`default_nettype none

module grey_error_diffusion_dither_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [gedd_pkg::RegIdxW-1:0]      cfg_idx_i,
  input  wire logic [gedd_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [gedd_pkg::PixW-1:0]         red_i,
  input  wire logic [gedd_pkg::PixW-1:0]         green_i,
  input  wire logic [gedd_pkg::PixW-1:0]         blue_i,
  input  wire logic [gedd_pkg::PixW-1:0]         alpha_i,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [gedd_pkg::PixW-1:0]              dithered_grey_o,
  output logic [gedd_pkg::LevelW-1:0]            level_o,
  output logic [gedd_pkg::PixW-1:0]              alpha_out_o,
  output logic                                   frame_end_o
);

  gedd_pkg::pix_t head;
  logic           head_valid;
  logic           head_pop;
  gedd_pkg::res_t res;

  gedd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .push         (push),
    .full         (full),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .alpha_i      (alpha_i),
    .head_o       (head),
    .head_valid_o (head_valid),
    .head_pop_i   (head_pop)
  );

  gedd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .head_pop_o   (head_pop),
    .empty        (empty),
    .pop          (pop),
    .res_o        (res)
  );

  assign dithered_grey_o = res.dithered_grey;
  assign level_o         = res.level;
  assign alpha_out_o     = res.alpha;
  assign frame_end_o     = res.frame_end;

endmodule

`default_nettype wire
